### rtl/tdpc_pkg.sv
// Shared widths and constants for the trial division prime counter.
// No dependencies; used by rtl/trial_division_prime_counter.sv.
`timescale 1ns / 1ps

package tdpc_pkg;

  localparam int CAND_W  = 31;
  localparam int DIV_W   = 16;
  localparam int SQ_W    = 32;
  localparam int COUNT_W = 32;
  localparam int LOAD_W  = 64;
  localparam int STEP_W  = 5;

  localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(CAND_W - 1);
  localparam logic [DIV_W-1:0]   FIRST_DIV  = DIV_W'(2);
  localparam logic [SQ_W-1:0]    FIRST_SQ   = SQ_W'(4);
  localparam logic [DIV_W-1:0]   MAX_DIV    = DIV_W'(46341);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

endpackage

### rtl/trial_division_prime_counter.sv
// Trial division prime tester with running prime count and load total.
// Depends on rtl/tdpc_pkg.sv.
`timescale 1ns / 1ps

// One candidate is tested at a time. For each trial divisor, the check state
// compares the running square of the divisor with the candidate, then a
// shared 17-bit restoring subtractor forms candidate mod divisor, one
// candidate bit per cycle over all 31 candidate bits. Candidates 0 and 1 go
// straight to the finish state. in_stall is high from acceptance until the
// result word has been placed in the output register, which holds it until
// it is taken. restart clears both totals before the candidate is counted;
// the count saturates, the load total wraps.
module trial_division_prime_counter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tdpc_pkg::CAND_W-1:0]  in_candidate,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_prime_flag,
  output logic [tdpc_pkg::DIV_W-1:0]   out_stop_divisor,
  output logic [tdpc_pkg::COUNT_W-1:0] out_prime_count,
  output logic [tdpc_pkg::LOAD_W-1:0]  out_load_total
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CHECK  = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [tdpc_pkg::CAND_W-1:0]  cand_r, cand_nxt;
  logic [tdpc_pkg::CAND_W-1:0]  dvd_r, dvd_nxt;
  logic [tdpc_pkg::DIV_W-1:0]   d_r, d_nxt;
  logic [tdpc_pkg::SQ_W-1:0]    sq_r, sq_nxt;
  logic [tdpc_pkg::DIV_W-1:0]   rem_r, rem_nxt;
  logic [tdpc_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         prime_r, prime_nxt;
  logic [tdpc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [tdpc_pkg::LOAD_W-1:0]  load_r, load_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_prime_r, out_prime_nxt;
  logic [tdpc_pkg::DIV_W-1:0]   out_stop_r, out_stop_nxt;
  logic [tdpc_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [tdpc_pkg::LOAD_W-1:0]  out_load_r, out_load_nxt;

  logic                         in_take;
  logic                         out_free;
  logic [tdpc_pkg::DIV_W:0]     trial;
  logic [tdpc_pkg::DIV_W:0]     diff;
  logic [tdpc_pkg::DIV_W-1:0]   rem_step;
  logic [tdpc_pkg::COUNT_W-1:0] count_upd;
  logic [tdpc_pkg::LOAD_W-1:0]  load_upd;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign trial    = {rem_r, dvd_r[tdpc_pkg::CAND_W-1]};
  assign diff     = trial - {1'b0, d_r};
  assign rem_step = diff[tdpc_pkg::DIV_W] ? trial[tdpc_pkg::DIV_W-1:0]
                                          : diff[tdpc_pkg::DIV_W-1:0];

  assign count_upd = (prime_r && (count_r != tdpc_pkg::COUNT_MAX)) ?
                     count_r + tdpc_pkg::COUNT_W'(1) : count_r;
  assign load_upd  = load_r + tdpc_pkg::LOAD_W'(d_r);

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    dvd_nxt       = dvd_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    prime_nxt     = prime_r;
    count_nxt     = count_r;
    load_nxt      = load_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_prime_nxt = out_prime_r;
    out_stop_nxt  = out_stop_r;
    out_count_nxt = out_count_r;
    out_load_nxt  = out_load_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cand_nxt  = in_candidate;
          d_nxt     = tdpc_pkg::FIRST_DIV;
          sq_nxt    = tdpc_pkg::FIRST_SQ;
          prime_nxt = 1'b0;
          if (in_restart) begin
            count_nxt = '0;
            load_nxt  = '0;
          end
          if (in_candidate < tdpc_pkg::CAND_W'(2)) begin
            d_nxt     = '0;
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > {1'b0, cand_r}) begin
          prime_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          dvd_nxt   = cand_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[tdpc_pkg::CAND_W-2:0], 1'b0};
        step_nxt = step_r + tdpc_pkg::STEP_W'(1);
        if (step_r == tdpc_pkg::LAST_STEP) begin
          if (rem_step == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            sq_nxt    = sq_r + tdpc_pkg::SQ_W'({d_r, 1'b1});
            d_nxt     = d_r + tdpc_pkg::DIV_W'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = prime_r;
          out_stop_nxt  = d_r;
          out_count_nxt = count_upd;
          out_load_nxt  = load_upd;
          count_nxt     = count_upd;
          load_nxt      = load_upd;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      load_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      load_r      <= load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    dvd_r       <= dvd_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    prime_r     <= prime_nxt;
    out_prime_r <= out_prime_nxt;
    out_stop_r  <= out_stop_nxt;
    out_count_r <= out_count_nxt;
    out_load_r  <= out_load_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_prime_flag   = out_prime_r;
  assign out_stop_divisor = out_stop_r;
  assign out_prime_count  = out_count_r;
  assign out_load_total   = out_load_r;

  a_word_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result word raised outside finish");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < d_r)
    else $error("partial remainder not below divisor");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> (d_r >= tdpc_pkg::FIRST_DIV && d_r <= tdpc_pkg::MAX_DIV))
    else $error("trial divisor out of range");

  a_prime_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_prime_r) |-> out_stop_r >= tdpc_pkg::FIRST_DIV)
    else $error("prime word with stop divisor below two");

endmodule

### sim/testbench.sv
// Self-checking bench for trial_division_prime_counter: queued candidates, a
// clocked driver that predicts each accepted word and a monitor that checks results.
// Depends on rtl/tdpc_pkg.sv and rtl/trial_division_prime_counter.sv.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [1:0] {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;

  typedef struct {
    logic [tdpc_pkg::CAND_W-1:0] candidate;
    logic                        restart;
    logic                        drain_first;
    phase_t                      phase;
  } candidate_t;

  typedef struct {
    logic                         prime_flag;
    logic [tdpc_pkg::DIV_W-1:0]   stop_divisor;
    logic [tdpc_pkg::COUNT_W-1:0] prime_count;
    logic [tdpc_pkg::LOAD_W-1:0]  load_total;
  } verdict_t;

  localparam int RANDOM_PER_PHASE = 20;
  localparam int SETTLE_CYCLES    = 200;
  localparam int REPORT_LIMIT     = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [tdpc_pkg::CAND_W-1:0] in_candidate = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_prime_flag;
  logic [tdpc_pkg::DIV_W-1:0] out_stop_divisor;
  logic [tdpc_pkg::COUNT_W-1:0] out_prime_count;
  logic [tdpc_pkg::LOAD_W-1:0] out_load_total;

  candidate_t candidate_queue[$];
  verdict_t awaited_verdicts[$];
  logic [tdpc_pkg::COUNT_W-1:0] prime_tally = '0;
  logic [tdpc_pkg::LOAD_W-1:0] load_tally = '0;
  phase_t cur_phase = PH_STEADY;

  longint unsigned cycles = 0;
  longint unsigned cycle_limit = 64'd1_000_000_000;
  longint unsigned cycle_budget = 0;
  bit run_done = 1'b0;
  int unsigned mismatches = 0;
  int unsigned tested = 0;
  int unsigned primes_seen = 0;
  int unsigned restarts_seen = 0;
  int unsigned deepest_stop = 0;

  trial_division_prime_counter DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_candidate(in_candidate),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_prime_flag(out_prime_flag),
    .out_stop_divisor(out_stop_divisor),
    .out_prime_count(out_prime_count),
    .out_load_total(out_load_total)
  );

  always #4 clk = ~clk;

  function automatic verdict_t trial_divide(input logic [tdpc_pkg::CAND_W-1:0] cand);
    verdict_t v;
    logic [31:0] d;
    v = '{default: '0};
    if (cand < 2) return v;
    d = 32'd2;
    while (64'(d) * 64'(d) <= 64'(cand)) begin
      if (cand % d == 0) begin
        v.stop_divisor = d[tdpc_pkg::DIV_W-1:0];
        return v;
      end
      d++;
    end
    v.prime_flag = 1'b1;
    v.stop_divisor = d[tdpc_pkg::DIV_W-1:0];
    return v;
  endfunction

  task automatic tally_candidate(input logic [tdpc_pkg::CAND_W-1:0] cand,
                                 input logic restart, output verdict_t v);
    v = trial_divide(cand);
    if (restart) begin
      prime_tally = '0;
      load_tally = '0;
    end
    load_tally += 64'(v.stop_divisor);
    if (v.prime_flag && prime_tally != tdpc_pkg::COUNT_MAX) prime_tally++;
    v.prime_count = prime_tally;
    v.load_total = load_tally;
  endtask

  function automatic int unsigned sender_idle_pct(input phase_t ph);
    case (ph)
      PH_SEND_IDLE: return 52;
      PH_BOTH: return 22;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(input phase_t ph);
    case (ph)
      PH_RECV_STALL: return 52;
      PH_BOTH: return 22;
      default: return 0;
    endcase
  endfunction

  // Budget time per trial divisor in the block; allow slack for gaps and stalls.
  task automatic queue_candidate(input logic [tdpc_pkg::CAND_W-1:0] cand,
                                 input logic restart, input logic drain_first,
                                 input phase_t ph);
    verdict_t v;
    v = trial_divide(cand);
    cycle_budget += 64'(32 * int'(v.stop_divisor) + 128);
    candidate_queue.push_back('{cand, restart, drain_first, ph});
  endtask

  function automatic logic [tdpc_pkg::CAND_W-1:0] random_candidate();
    int unsigned kind;
    int unsigned p;
    int unsigned q;
    kind = $urandom_range(99);
    if (kind < 45) return tdpc_pkg::CAND_W'($urandom_range(3000));
    if (kind < 75) begin
      p = $urandom_range(97, 2);
      q = $urandom_range(32'h7FFF_FFFF / p, 1);
      return tdpc_pkg::CAND_W'(p * q);
    end
    if (kind < 95) return tdpc_pkg::CAND_W'($urandom_range(1 << 18, 3000));
    q = $urandom_range(511, 3);
    return tdpc_pkg::CAND_W'(q * q);
  endfunction

  always @(posedge clk) begin : drive_proc
    verdict_t v;
    candidate_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tally_candidate(in_candidate, in_restart, v);
        awaited_verdicts.push_back(v);
        tested++;
        if (v.prime_flag) primes_seen++;
        if (in_restart) restarts_seen++;
        if (32'(v.stop_divisor) > deepest_stop) deepest_stop = 32'(v.stop_divisor);
      end
      if (!in_valid || !in_stall) begin
        if (candidate_queue.size() != 0
            && !(candidate_queue[0].drain_first && awaited_verdicts.size() != 0)
            && $urandom_range(99) >= sender_idle_pct(candidate_queue[0].phase)) begin
          nxt = candidate_queue.pop_front();
          in_valid <= 1'b1;
          in_candidate <= nxt.candidate;
          in_restart <= nxt.restart;
          cur_phase <= nxt.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct(cur_phase));
    end
  end

  always @(posedge clk) begin : check_proc
    verdict_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result word with nothing awaited: prime=%0d stop=%0d %s",
                   $time, out_prime_flag, out_stop_divisor,
                   $sformatf("count=%0d load=%0d", out_prime_count, out_load_total));
      end else begin
        w = awaited_verdicts.pop_front();
        if (out_prime_flag !== w.prime_flag || out_stop_divisor !== w.stop_divisor
            || out_prime_count !== w.prime_count || out_load_total !== w.load_total) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch exp prime=%0d stop=%0d count=%0d load=%0d, %s",
                     $time, w.prime_flag, w.stop_divisor, w.prime_count, w.load_total,
                     $sformatf("got prime=%0d stop=%0d count=%0d load=%0d",
                               out_prime_flag, out_stop_divisor, out_prime_count,
                               out_load_total));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > cycle_limit && !run_done) begin
      $display("timed out after %0d cycles, %0d words still awaited", cycles,
               awaited_verdicts.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus_proc
    phase_t ph;
    int i;
    queue_candidate(31'd1, 1'b1, 1'b0, PH_STEADY);
    queue_candidate(31'd0, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd2, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd3, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd4, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd5, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd9, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd17, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd25, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd49, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd994009, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd1000003, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'h7FFF_FFFE, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'h4000_0000, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'h5555_5555, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'h2AAA_AAAA, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'h7FFF_FFFF, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd7, 1'b1, 1'b0, PH_STEADY);
    queue_candidate(31'd1, 1'b0, 1'b0, PH_STEADY);
    queue_candidate(31'd11, 1'b0, 1'b0, PH_STEADY);
    ph = PH_STEADY;
    repeat (4) begin
      for (i = 0; i < RANDOM_PER_PHASE; i++)
        queue_candidate(random_candidate(), ($urandom_range(99) < 8), (i == 0), ph);
      ph = phase_t'(ph + 1);
    end
    cycle_limit = 4 * cycle_budget + 10000;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (candidate_queue.size() != 0 || in_valid || awaited_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    run_done = 1'b1;
    $display("tested %0d candidates (%0d prime, %0d with restart), deepest stop divisor %0d",
             tested, primes_seen, restarts_seen, deepest_stop);
    $display("four idle/stall phases, %0d mismatches, %0d cycles", mismatches, cycles);
    if (mismatches == 0 && awaited_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
